// ===== hdl/mrr_pkg.sv =====
// ============================================================================
// mrr_pkg: matrix ring rotation shared definitions
// Sizes, request/response payload types and register and function codes.
// ============================================================================
`default_nettype none

package mrr_pkg;

    localparam int MAX_DIM     = 64;
    localparam int ELEM_WIDTH  = 32;
    localparam int DIM_W       = 7;
    localparam int ROW_W       = 6;
    localparam int ROT_W       = 31;
    localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int CNT_W       = ADDR_W + 1;
    localparam int RING_N      = MAX_DIM / 2;
    localparam int RING_W      = $clog2(RING_N);
    localparam int POS_W       = $clog2(4 * MAX_DIM - 4);
    localparam int PADDR_W     = 4;
    localparam int PDATA_W     = 32;
    localparam int DIM_MIN     = 2;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_READ = 1'b1;

    localparam logic [1:0] REG_ROWS = 2'd0;
    localparam logic [1:0] REG_COLS = 2'd1;
    localparam logic [1:0] REG_ROT  = 2'd2;

    typedef struct packed {
        logic                           func;
        logic signed [ELEM_WIDTH-1:0]   elem_in;
    } in_req_t;

    typedef struct packed {
        logic signed [ELEM_WIDTH-1:0]   elem_out;
        logic [ROW_W-1:0]               out_row;
        logic [ROW_W-1:0]               out_col;
        logic                           last_elem;
    } out_rsp_t;

endpackage

`default_nettype wire

// ===== hdl/matrix_ring_rotation.sv =====
// ============================================================================
// matrix_ring_rotation: concentric ring rotation of a stored matrix
// Loads a matrix row-major, then streams it back with every ring rotated
// counter-clockwise by the configured step count.
// ============================================================================
// Usage:
//   Request channel (in_valid/in_stall/in_data): func 0 loads the next
//   element row-major (no response, ignored once R*C elements are held);
//   func 1 reads the next element of the rotated matrix, row-major.
//   Response channel (out_valid/out_stall/out_data): one response per read
//   with element, row, column and a last-cell flag.
//   Configuration over APB: rows at 0x0, cols at 0x4, rotation at 0x8.
//   Timing: a load is written to the store as it is accepted. A read runs
//   ring position with residue fetch, source lookup, address multiply with
//   the element memory read, and the response register load in turn before
//   the next accept. One request is in flight at a time.
//   Setup pass: after reset and after every register write the block
//   recomputes the read position and the rotation residue of each ring;
//   in_stall stays high meanwhile.
//   A stalled response is held in the output register; a following read
//   waits at its last step until that register frees up.
// ============================================================================
`default_nettype none

module matrix_ring_rotation (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire mrr_pkg::in_req_t              in_data,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output mrr_pkg::out_rsp_t                  out_data,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [mrr_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [mrr_pkg::PDATA_W-1:0]   pwdata,
    output logic [mrr_pkg::PDATA_W-1:0]        prdata,
    output logic                               pready
);

    import mrr_pkg::*;

    localparam int CB_W = $clog2(ROT_W);

    localparam logic [2:0] ST_INIT = 3'd0;
    localparam logic [2:0] ST_IDLE = 3'd1;
    localparam logic [2:0] ST_RING = 3'd2;
    localparam logic [2:0] ST_SRC  = 3'd3;
    localparam logic [2:0] ST_ADDR = 3'd4;
    localparam logic [2:0] ST_DATA = 3'd5;

    localparam logic PH_DIV = 1'b0;
    localparam logic PH_MOD = 1'b1;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        r = v;
        if (v < DIM_W'(DIM_MIN))
            r = DIM_W'(DIM_MIN);
        else if (v > DIM_W'(MAX_DIM))
            r = DIM_W'(MAX_DIM);
        return r;
    endfunction

    // configuration registers
    logic [DIM_W-1:0]       rows_reg;
    logic [DIM_W-1:0]       cols_reg;
    logic [ROT_W-1:0]       rot_reg;

    // control state
    logic [2:0]             state_reg, state_next;
    logic                   phase_reg, phase_next;
    logic [CB_W-1:0]        cnt_reg, cnt_next;
    logic [RING_W-1:0]      ring_reg, ring_next;
    logic [ADDR_W-1:0]      div_num_reg, div_num_next;
    logic [DIM_W-1:0]       div_rem_reg, div_rem_next;
    logic [POS_W-1:0]       mod_rem_reg, mod_rem_next;
    logic [ADDR_W-1:0]      rd_cnt_reg, rd_cnt_next;
    logic [ROW_W-1:0]       row_reg, row_next;
    logic [ROW_W-1:0]       col_reg, col_next;
    logic [CNT_W-1:0]       load_cnt_reg, load_cnt_next;
    logic                   out_valid_reg, out_valid_next;

    // per-request payload
    logic [ROW_W-1:0]       cur_i_reg, cur_j_reg;
    logic                   cur_last_reg;
    logic [ROW_W-1:0]       c_reg;
    logic                   inring_reg;
    logic [POS_W-1:0]       k_reg, len_reg, h_reg, w_reg;
    logic [POS_W-1:0]       rr_reg;
    logic [ROW_W-1:0]       rlast_reg, clast_reg;
    logic [ROW_W-1:0]       src_i_reg, src_j_reg;
    logic [ELEM_WIDTH-1:0]  rd_data_reg;
    out_rsp_t               out_data_reg;

    logic [ELEM_WIDTH-1:0]  mem [STORE_DEPTH];
    logic [POS_W-1:0]       res_tab [RING_N];
    logic                   res_we;
    logic [POS_W-1:0]       res_wdata;

    logic [DIM_W-1:0]       dim_r, dim_c, min_rc;
    logic [DIM_W-2:0]       rings;
    logic [CNT_W-1:0]       cells;
    logic                   in_acc, cfg_wr, out_free;
    logic                   mem_we, mem_re;
    logic [CNT_W-1:0]       raddr_full;
    logic [ADDR_W-1:0]      mem_raddr;

    // read position
    logic                   oob;
    logic [ADDR_W-1:0]      p_eff;
    logic [ROW_W-1:0]       i_eff, j_eff;
    logic [CNT_W-1:0]       p_inc;
    logic                   wrap, col_wrap;

    // setup pass
    logic [DIM_W-1:0]       div_step, div_sub;
    logic                   div_ge;
    logic [POS_W:0]         mod_step;
    logic [POS_W-1:0]       ring_len, lsum;
    logic                   mod_ge;

    // ring position
    logic [DIM_W-1:0]       ti, tj, r_dist, c_dist, c_min, rl7, cl7;
    logic [POS_W-1:0]       hh, ww, kk, cp, rlp, clp;

    // source cell
    logic [POS_W-1:0]       rr, s0, s1, s2, s3, ci_p;
    logic [ROW_W-1:0]       si, sj;

    assign dim_r  = clamp_dim(rows_reg);
    assign dim_c  = clamp_dim(cols_reg);
    assign min_rc = (dim_r < dim_c) ? dim_r : dim_c;
    assign rings  = min_rc[DIM_W-1:1];
    assign cells  = CNT_W'(dim_r) * CNT_W'(dim_c);

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign cfg_wr    = psel && penable && pwrite;
    assign pready    = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    assign mem_we = in_acc && (in_data.func == FUNC_LOAD) && (load_cnt_reg < cells);
    assign mem_re = (state_reg == ST_ADDR);

    always_comb
    begin
        case (paddr[3:2])
            REG_ROWS: prdata = PDATA_W'(rows_reg);
            REG_COLS: prdata = PDATA_W'(cols_reg);
            REG_ROT:  prdata = PDATA_W'(rot_reg);
            default:  prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg <= DIM_W'(DIM_MIN);
            cols_reg <= DIM_W'(DIM_MIN);
            rot_reg  <= '0;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                REG_ROWS: rows_reg <= pwdata[DIM_W-1:0];
                REG_COLS: cols_reg <= pwdata[DIM_W-1:0];
                REG_ROT:  rot_reg  <= pwdata[ROT_W-1:0];
                default:  ;
            endcase
        end
    end

    // read position, with an out-of-range count restarting at cell 0
    assign oob      = {1'b0, rd_cnt_reg} >= cells;
    assign p_eff    = oob ? '0 : rd_cnt_reg;
    assign i_eff    = oob ? '0 : row_reg;
    assign j_eff    = oob ? '0 : col_reg;
    assign p_inc    = CNT_W'(p_eff) + CNT_W'(1);
    assign wrap     = p_inc >= cells;
    assign col_wrap = (DIM_W'(j_eff) + DIM_W'(1)) == dim_c;

    // setup pass datapath: row/col = p div/mod C, residue = rotation mod L
    assign div_step = {div_rem_reg[DIM_W-2:0], div_num_reg[ADDR_W-1]};
    assign div_ge   = div_step >= dim_c;
    assign div_sub  = div_ge ? (div_step - dim_c) : div_step;
    assign lsum     = POS_W'(dim_r) + POS_W'(dim_c) - (POS_W'(ring_reg) << 2);
    assign ring_len = (lsum << 1) - POS_W'(4);
    assign mod_step = {mod_rem_reg, rot_reg[cnt_reg]};
    assign mod_ge   = mod_step >= {1'b0, ring_len};

    // ring index and position of the current cell
    assign ti     = DIM_W'(cur_i_reg);
    assign tj     = DIM_W'(cur_j_reg);
    assign r_dist = dim_r - DIM_W'(1) - ti;
    assign c_dist = dim_c - DIM_W'(1) - tj;

    always_comb
    begin
        c_min = (ti < tj) ? ti : tj;
        if (r_dist < c_min)
            c_min = r_dist;
        if (c_dist < c_min)
            c_min = c_dist;
    end

    assign rl7 = dim_r - DIM_W'(1) - c_min;
    assign cl7 = dim_c - DIM_W'(1) - c_min;
    assign cp  = POS_W'(c_min);
    assign rlp = POS_W'(rl7);
    assign clp = POS_W'(cl7);
    assign hh  = POS_W'(dim_r) - (cp << 1) - POS_W'(1);
    assign ww  = POS_W'(dim_c) - (cp << 1) - POS_W'(1);

    always_comb
    begin
        if (tj == c_min && ti < rl7)
            kk = POS_W'(ti) - cp;
        else if (ti == rl7 && tj < cl7)
            kk = hh + POS_W'(tj) - cp;
        else if (tj == cl7 && ti > c_min)
            kk = hh + ww + rlp - POS_W'(ti);
        else
            kk = (hh << 1) + ww + clp - POS_W'(tj);
    end

    // source cell on the ring
    assign rr   = rr_reg;
    assign s0   = (k_reg >= rr) ? (k_reg - rr) : (k_reg + len_reg - rr);
    assign s1   = s0 - h_reg;
    assign s2   = s1 - w_reg;
    assign s3   = s2 - h_reg;
    assign ci_p = POS_W'(c_reg);

    always_comb
    begin
        if (!inring_reg)
        begin
            si = cur_i_reg;
            sj = cur_j_reg;
        end
        else if (s0 < h_reg)
        begin
            si = ROW_W'(ci_p + s0);
            sj = c_reg;
        end
        else if (s1 < w_reg)
        begin
            si = rlast_reg;
            sj = ROW_W'(ci_p + s1);
        end
        else if (s2 < h_reg)
        begin
            si = ROW_W'(POS_W'(rlast_reg) - s2);
            sj = clast_reg;
        end
        else
        begin
            si = c_reg;
            sj = ROW_W'(POS_W'(clast_reg) - s3);
        end
    end

    assign raddr_full = CNT_W'(src_i_reg) * CNT_W'(dim_c) + CNT_W'(src_j_reg);
    assign mem_raddr  = raddr_full[ADDR_W-1:0];

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        cnt_next       = cnt_reg;
        ring_next      = ring_reg;
        div_num_next   = div_num_reg;
        div_rem_next   = div_rem_reg;
        mod_rem_next   = mod_rem_reg;
        rd_cnt_next    = rd_cnt_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        load_cnt_next  = load_cnt_reg;
        out_valid_next = out_valid_reg && out_stall;
        res_we         = 1'b0;
        res_wdata      = mod_ge ? POS_W'(mod_step - {1'b0, ring_len}) : POS_W'(mod_step);

        case (state_reg)
            ST_INIT:
            begin
                if (phase_reg == PH_DIV)
                begin
                    div_num_next = {div_num_reg[ADDR_W-2:0], div_ge};
                    div_rem_next = div_sub;
                    cnt_next     = cnt_reg + CB_W'(1);
                    if (cnt_reg == CB_W'(ADDR_W - 1))
                    begin
                        row_next     = div_num_next[ROW_W-1:0];
                        col_next     = div_sub[ROW_W-1:0];
                        phase_next   = PH_MOD;
                        cnt_next     = CB_W'(ROT_W - 1);
                        ring_next    = '0;
                        mod_rem_next = '0;
                    end
                end
                else
                begin
                    mod_rem_next = res_wdata;
                    cnt_next     = cnt_reg - CB_W'(1);
                    if (cnt_reg == '0)
                    begin
                        res_we       = 1'b1;
                        mod_rem_next = '0;
                        cnt_next     = CB_W'(ROT_W - 1);
                        ring_next    = ring_reg + RING_W'(1);
                        if ((DIM_W-1)'(ring_reg) + (DIM_W-1)'(1) == rings)
                            state_next = ST_IDLE;
                    end
                end
            end
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (in_data.func == FUNC_READ)
                    begin
                        state_next  = ST_RING;
                        rd_cnt_next = wrap ? '0 : p_inc[ADDR_W-1:0];
                        if (wrap)
                        begin
                            row_next = '0;
                            col_next = '0;
                        end
                        else if (col_wrap)
                        begin
                            row_next = i_eff + ROW_W'(1);
                            col_next = '0;
                        end
                        else
                        begin
                            row_next = i_eff;
                            col_next = j_eff + ROW_W'(1);
                        end
                    end
                    else if (mem_we)
                    begin
                        load_cnt_next = load_cnt_reg + CNT_W'(1);
                    end
                end
            end
            ST_RING:
                state_next = ST_SRC;
            ST_SRC:
                state_next = ST_ADDR;
            ST_ADDR:
                state_next = ST_DATA;
            ST_DATA:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
                state_next = ST_INIT;
        endcase

        if (cfg_wr)
        begin
            state_next   = ST_INIT;
            phase_next   = PH_DIV;
            cnt_next     = '0;
            div_num_next = rd_cnt_reg;
            div_rem_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            phase_reg     <= PH_DIV;
            cnt_reg       <= '0;
            ring_reg      <= '0;
            div_num_reg   <= '0;
            div_rem_reg   <= '0;
            mod_rem_reg   <= '0;
            rd_cnt_reg    <= '0;
            row_reg       <= '0;
            col_reg       <= '0;
            load_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            cnt_reg       <= cnt_next;
            ring_reg      <= ring_next;
            div_num_reg   <= div_num_next;
            div_rem_reg   <= div_rem_next;
            mod_rem_reg   <= mod_rem_next;
            rd_cnt_reg    <= rd_cnt_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            load_cnt_reg  <= load_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && in_acc)
        begin
            cur_i_reg    <= i_eff;
            cur_j_reg    <= j_eff;
            cur_last_reg <= wrap;
        end
        if (state_reg == ST_RING)
        begin
            c_reg      <= c_min[ROW_W-1:0];
            inring_reg <= c_min < DIM_W'(rings);
            k_reg      <= kk;
            len_reg    <= (hh + ww) << 1;
            h_reg      <= hh;
            w_reg      <= ww;
            rlast_reg  <= rl7[ROW_W-1:0];
            clast_reg  <= cl7[ROW_W-1:0];
            rr_reg     <= res_tab[c_min[RING_W-1:0]];
        end
        if (state_reg == ST_SRC)
        begin
            src_i_reg <= si;
            src_j_reg <= sj;
        end
        if (state_reg == ST_DATA && out_free)
        begin
            out_data_reg.elem_out  <= rd_data_reg;
            out_data_reg.out_row   <= cur_i_reg;
            out_data_reg.out_col   <= cur_j_reg;
            out_data_reg.last_elem <= cur_last_reg;
        end
        if (res_we)
            res_tab[ring_reg] <= res_wdata;
    end

    // element store
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[load_cnt_reg[ADDR_W-1:0]] <= in_data.elem_in;
        if (mem_re)
            rd_data_reg <= mem[mem_raddr];
    end

    a_read_enters_ring: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && in_data.func == FUNC_READ && !cfg_wr) |=> state_reg == ST_RING)
        else $error("read request did not start ring lookup");

    a_residue_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SRC && inring_reg) |-> rr < len_reg)
        else $error("ring residue not below ring length");

    a_source_in_matrix: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ADDR) |-> (DIM_W'(src_i_reg) < dim_r && DIM_W'(src_j_reg) < dim_c))
        else $error("source cell outside matrix");

    a_response_from_data: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_DATA)
        else $error("response without completed read");

    a_load_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        load_cnt_reg <= CNT_W'(STORE_DEPTH))
        else $error("load count beyond store depth");

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// ============================================================================
// tb_top: matrix ring rotation regression
// Loads matrices over the request channel, reads them back and compares
// every response field with a shadow copy of the store that rotates each
// ring on the fly. Dimensions and rotation are swept over APB between
// phases, with random gaps and stalls on both channels, a long response
// hold-off and a stretch of back-to-back traffic.
// ============================================================================
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import mrr_pkg::*;

    localparam int HALF_PERIOD   = 6;
    localparam int RESET_CYCLES  = 4;
    localparam int IDLE_PCT      = 22;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 16;
    localparam int DRAIN_LIMIT   = 5000;
    localparam int TAIL_CYCLES   = 20;
    localparam int PRINT_LIMIT   = 40;
    localparam int SWEEP_PHASES  = 6;

    localparam logic [1:0]       REG_SPARE = 2'd3;
    localparam logic [ROT_W-1:0] ROT_MAX   = '1;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    in_req_t              in_data;
    logic                 out_valid;
    logic                 out_stall;
    out_rsp_t             out_data;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [PDATA_W-1:0]   pwdata;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    // shadow of the block's registers and store
    logic [DIM_W-1:0]      cfg_rows;
    logic [DIM_W-1:0]      cfg_cols;
    logic [ROT_W-1:0]      cfg_rot;
    logic [ELEM_WIDTH-1:0] shadow_matrix [STORE_DEPTH];
    int unsigned           shadow_loaded;
    int unsigned           shadow_read_pos;
    out_rsp_t              rotated_cells_due [$];

    int mismatch_count;
    bit steady;
    bit hold_req;

    matrix_ring_rotation uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always #HALF_PERIOD clk = ~clk;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatch_count < PRINT_LIMIT)
            $display("%0t: %s mismatch: got 0x%08h, want 0x%08h", $time, what, got, want);
        mismatch_count++;
    endtask

    function automatic int unsigned sat_dim(input logic [DIM_W-1:0] v);
        if (v < DIM_MIN)
            return DIM_MIN;
        if (v > MAX_DIM)
            return MAX_DIM;
        return 32'(v);
    endfunction

    function automatic int unsigned min2(input int unsigned a, input int unsigned b);
        return (a < b) ? a : b;
    endfunction

    // position of (row, col) along ring band: left column down, bottom, right up, top
    function automatic int unsigned ring_offset(input int unsigned nr, input int unsigned nc,
                                                input int unsigned band,
                                                input int unsigned row,
                                                input int unsigned col);
        int unsigned h;
        int unsigned w;
        h = nr - 2 * band - 1;
        w = nc - 2 * band - 1;
        if (col == band && row < nr - 1 - band)
            return row - band;
        if (row == nr - 1 - band && col < nc - 1 - band)
            return h + col - band;
        if (col == nc - 1 - band && row > band)
            return h + w + (nr - 1 - band - row);
        return 2 * h + w + (nc - 1 - band - col);
    endfunction

    function automatic void ring_locate(input int unsigned nr, input int unsigned nc,
                                        input int unsigned band, input int unsigned pos,
                                        output int unsigned row, output int unsigned col);
        int unsigned h;
        int unsigned w;
        int unsigned k;
        h = nr - 2 * band - 1;
        w = nc - 2 * band - 1;
        k = pos;
        if (k < h)
        begin
            row = band + k;
            col = band;
            return;
        end
        k -= h;
        if (k < w)
        begin
            row = nr - 1 - band;
            col = band + k;
            return;
        end
        k -= w;
        if (k < h)
        begin
            row = nr - 1 - band - k;
            col = nc - 1 - band;
            return;
        end
        k -= h;
        row = band;
        col = nc - 1 - band - k;
    endfunction

    // apply one accepted request to the shadow; a read queues its rotated cell
    function automatic void ring_rotate_step(input in_req_t req);
        int unsigned nr;
        int unsigned nc;
        int unsigned cells;
        int unsigned pos;
        int unsigned row;
        int unsigned col;
        int unsigned band;
        int unsigned len;
        int unsigned src;
        int unsigned srow;
        int unsigned scol;
        out_rsp_t    rsp;
        nr = sat_dim(cfg_rows);
        nc = sat_dim(cfg_cols);
        cells = nr * nc;
        if (req.func == FUNC_LOAD)
        begin
            if (shadow_loaded < cells)
            begin
                shadow_matrix[shadow_loaded] = req.elem_in;
                shadow_loaded++;
            end
            return;
        end
        pos = (shadow_read_pos >= cells) ? 0 : shadow_read_pos;
        row = pos / nc;
        col = pos % nc;
        band = min2(min2(row, col), min2(nr - 1 - row, nc - 1 - col));
        srow = row;
        scol = col;
        if (band < min2(nr, nc) / 2)
        begin
            len = 2 * ((nr - 2 * band) + (nc - 2 * band)) - 4;
            src = (ring_offset(nr, nc, band, row, col) + len - (cfg_rot % len)) % len;
            ring_locate(nr, nc, band, src, srow, scol);
        end
        rsp.elem_out  = shadow_matrix[srow * nc + scol];
        rsp.out_row   = row[ROW_W-1:0];
        rsp.out_col   = col[ROW_W-1:0];
        rsp.last_elem = (pos == cells - 1);
        shadow_read_pos = (pos + 1 >= cells) ? 0 : pos + 1;
        rotated_cells_due.push_back(rsp);
    endfunction

    task automatic send_request(input logic func, input logic [ELEM_WIDTH-1:0] value);
        int      gap;
        in_req_t req;
        req.func    = func;
        req.elem_in = value;
        gap = (!steady && $urandom_range(99) < IDLE_PCT) ? $urandom_range(1, 3) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        ring_rotate_step(req);
    endtask

    task automatic drop_request();
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        int waited;
        waited = 0;
        while (rotated_cells_due.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (rotated_cells_due.size() != 0)
        begin
            report_mismatch("missing responses", 32'(rotated_cells_due.size()), '0);
            rotated_cells_due.delete();
        end
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [PDATA_W-1:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!pready);
        case (idx)
            REG_ROWS: cfg_rows = value[DIM_W-1:0];
            REG_COLS: cfg_cols = value[DIM_W-1:0];
            REG_ROT:  cfg_rot  = value[ROT_W-1:0];
            default:  ;
        endcase
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apply_setting(input logic [31:0] rows_word, input logic [31:0] cols_word,
                                 input logic [31:0] rot_word);
        drop_request();
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge clk);
        write_reg(REG_ROWS, rows_word);
        write_reg(REG_COLS, cols_word);
        write_reg(REG_ROT, rot_word);
    endtask

    task automatic fill_to_capacity();
        while (shadow_loaded < sat_dim(cfg_rows) * sat_dim(cfg_cols))
            send_request(FUNC_LOAD, $urandom);
    endtask

    task automatic mixed_traffic(input int reads, input int load_pct);
        int done;
        done = 0;
        while (done < reads)
        begin
            if ($urandom_range(99) < load_pct)
                send_request(FUNC_LOAD, $urandom);
            else
            begin
                send_request(FUNC_READ, $urandom);
                done++;
            end
        end
    endtask

    function automatic logic [31:0] pick_dim_word();
        logic [31:0] w;
        w = $urandom;
        if ($urandom_range(5) == 0)
            w[DIM_W-1:0] = DIM_W'($urandom_range(0, 1));
        else
            w[DIM_W-1:0] = DIM_W'($urandom_range(2, 9));
        if ($urandom_range(1) == 0)
            w[31:DIM_W] = '0;
        return w;
    endfunction

    // 2x2 default after reset: extremes, one dropped load, wrap of the read position
    task automatic test_reset_defaults();
        send_request(FUNC_LOAD, 32'h8000_0000);
        send_request(FUNC_LOAD, 32'h7FFF_FFFF);
        send_request(FUNC_LOAD, 32'h0000_0000);
        send_request(FUNC_LOAD, 32'hFFFF_FFFF);
        send_request(FUNC_LOAD, 32'h1234_5678);
        repeat (5) send_request(FUNC_READ, $urandom);
    endtask

    // odd square: center cell lies outside every ring
    task automatic test_odd_square_rotation();
        apply_setting(3, 3, 1);
        fill_to_capacity();
        repeat (9) send_request(FUNC_READ, $urandom);
    endtask

    task automatic test_setting_sweep();
        logic [31:0] rot_word;
        for (int p = 0; p < SWEEP_PHASES; p++)
        begin
            case ($urandom_range(2))
                0:       rot_word = $urandom_range(0, 40);
                1:       rot_word = $urandom;
                default: rot_word = $urandom_range(1) ? {1'b0, ROT_MAX} : 32'd0;
            endcase
            apply_setting(pick_dim_word(), pick_dim_word(), rot_word);
            fill_to_capacity();
            mixed_traffic(24, 20);
        end
    endtask

    task automatic test_steady_stream();
        apply_setting(6, 6, 10);
        steady = 1'b1;
        fill_to_capacity();
        mixed_traffic(80, 15);
        drop_request();
        wait_drained();
        steady = 1'b0;
    endtask

    // rows written above range saturate to the tallest matrix; full pass plus wrap
    task automatic test_full_capacity();
        apply_setting(32'h7F, 2, {1'b0, ROT_MAX});
        fill_to_capacity();
        repeat (MAX_DIM * 2 + 1) send_request(FUNC_READ, $urandom);
    endtask

    task automatic test_extreme_shapes();
        apply_setting(2, 100, {1'b1, ROT_MAX});
        write_reg(REG_SPARE, $urandom);
        mixed_traffic(40, 10);
        apply_setting(1, 0, 1);
        mixed_traffic(10, 0);
    endtask

    task automatic test_output_backpressure();
        apply_setting(5, 7, 3);
        fill_to_capacity();
        hold_req = 1'b1;
        repeat (12) send_request(FUNC_READ, $urandom);
        mixed_traffic(20, 10);
        drop_request();
        wait_drained();
        mixed_traffic(20, 10);
    endtask

    // response side: random stalls, long hold-off on request
    initial
    begin
        int hold_left;
        hold_left = 0;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
        end
    end

    always @(posedge clk)
    begin
        out_rsp_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (rotated_cells_due.size() == 0)
                report_mismatch("unexpected response", out_data.elem_out, '0);
            else
            begin
                want = rotated_cells_due.pop_front();
                if (out_data.elem_out !== want.elem_out)
                    report_mismatch("elem_out", out_data.elem_out, want.elem_out);
                if (out_data.out_row !== want.out_row)
                    report_mismatch("out_row", 32'(out_data.out_row), 32'(want.out_row));
                if (out_data.out_col !== want.out_col)
                    report_mismatch("out_col", 32'(out_data.out_col), 32'(want.out_col));
                if (out_data.last_elem !== want.last_elem)
                    report_mismatch("last_elem", 32'(out_data.last_elem),
                                    32'(want.last_elem));
            end
        end
    end

    initial
    begin
        #8000000;
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_data  = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        steady   = 1'b0;
        hold_req = 1'b0;
        mismatch_count  = 0;
        cfg_rows        = DIM_W'(DIM_MIN);
        cfg_cols        = DIM_W'(DIM_MIN);
        cfg_rot         = '0;
        shadow_loaded   = 0;
        shadow_read_pos = 0;
        foreach (shadow_matrix[i])
            shadow_matrix[i] = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_odd_square_rotation();
        test_setting_sweep();
        test_steady_stream();
        test_full_capacity();
        test_extreme_shapes();
        test_output_backpressure();

        drop_request();
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
hdl/mrr_pkg.sv
hdl/matrix_ring_rotation.sv
tb/tb_top.sv
